FILE: rtl/core/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg: shared types and constants for the card number classifier
// Field widths, decimal digit layout, verdict codes, FSM states and the
// small digit-level helper functions used by the converter and the scanner.
// ----------------------------------------------------------------------------
package lcc_pkg;

  // Field widths
  localparam int CARD_W    = 63;
  localparam int VERDICT_W = 2;

  // Longest accepted number, in decimal digits
  localparam int MAX_DIGITS = 16;

  // Decimal layout: 19 digits cover 2^63-1, padded to an even count so
  // digits can be scanned in (even, odd) pairs
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int NUM_PAIRS  = NUM_DIGITS / 2;
  localparam int PAIR_W     = $clog2(NUM_PAIRS);
  localparam int LEN_W      = $clog2(NUM_DIGITS + 1);

  // Binary to BCD conversion: shift-add-3, a few bits per cycle
  localparam int BITS_PER_STEP = 3;
  localparam int CONV_STEPS    = CARD_W / BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(CONV_STEPS);

  // Accepted lengths
  localparam logic [LEN_W-1:0] LEN_A = LEN_W'(13);
  localparam logic [LEN_W-1:0] LEN_B = LEN_W'(15);
  localparam logic [LEN_W-1:0] LEN_C = LEN_W'(16);

  // Prefix digits
  localparam logic [DIGIT_W-1:0] AMEX_HI   = 4'd3;
  localparam logic [DIGIT_W-1:0] AMEX_LO_A = 4'd4;
  localparam logic [DIGIT_W-1:0] AMEX_LO_B = 4'd7;
  localparam logic [DIGIT_W-1:0] MC_HI     = 4'd5;
  localparam logic [DIGIT_W-1:0] MC_LO_MAX = 4'd5;
  localparam logic [DIGIT_W-1:0] VISA_HI   = 4'd4;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_INVALID    = 2'd0,
    VERDICT_AMEX       = 2'd1,
    VERDICT_MASTERCARD = 2'd2,
    VERDICT_VISA       = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_FINISH
  } lcc_state_t;

  // One shift-add-3 step: correct each digit, then shift one bit in
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic bit_in);
    logic [BCD_W-1:0]   adj;
    logic [DIGIT_W-1:0] d;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[i*DIGIT_W +: DIGIT_W];
      if (d >= 4'd5) begin
        d = d + 4'd3;
      end
      adj[i*DIGIT_W +: DIGIT_W] = d;
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  // Doubled digit with its two decimal digits added
  function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] t;
    t = {d, 1'b0};
    if (t >= 5'd10) begin
      t = t - 5'd9;
    end
    return t[DIGIT_W-1:0];
  endfunction

  // Running sum kept modulo 10; inputs are at most 9 each
  function automatic logic [DIGIT_W-1:0] mod10_add(input logic [DIGIT_W-1:0] acc,
                                                   input logic [DIGIT_W-1:0] a,
                                                   input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W:0] s;
    s = {1'b0, acc} + {1'b0, a} + {1'b0, b};
    if (s >= 5'd20) begin
      s = s - 5'd20;
    end else if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[DIGIT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/lcc_bcd_conv.sv
// ----------------------------------------------------------------------------
// lcc_bcd_conv: serial binary to BCD converter
// Shift-add-3 conversion of the card number, a few bits per cycle, MSB
// first. Pulses done for one cycle once the decimal digits are final.
// ----------------------------------------------------------------------------
module lcc_bcd_conv
  import lcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [CARD_W-1:0] number,
  output logic              done,
  output logic [BCD_W-1:0]  bcd
);

  logic [CARD_W-1:0]     bin_sh;
  logic [BCD_W-1:0]      bcd_next;
  logic [STEP_CNT_W-1:0] step_cnt;
  logic                  busy;

  // Several dependent shift-add-3 steps per cycle
  always_comb begin
    bcd_next = bcd;
    for (int j = 0; j < BITS_PER_STEP; j++) begin
      bcd_next = dabble_step(bcd_next, bin_sh[CARD_W-1-j]);
    end
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == STEP_CNT_W'(CONV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: binary shifter and digit register
  always_ff @(posedge clk) begin
    if (start) begin
      bin_sh <= number;
      bcd    <= '0;
    end else if (busy) begin
      bin_sh <= bin_sh << BITS_PER_STEP;
      bcd    <= bcd_next;
    end
  end

endmodule

FILE: rtl/core/card_number_luhn_classifier.sv
// ----------------------------------------------------------------------------
// card_number_luhn_classifier: card brand and Luhn check
// Converts a binary card number to decimal, then scans the digits to find
// length, leading digits and the Luhn mod-10 sum, and gives one verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: card_number with in_valid / in_stall. An item is taken
//   when in_valid is high and in_stall is low. Output channel: verdict with
//   out_valid / out_stall (0 invalid, 1 amex, 2 mastercard, 3 visa).
//   One item is in work at a time. After acceptance the number goes through
//   the binary to BCD converter, a handoff of its digits into the scan
//   register, then a digit scan (two digits per cycle), then the finish
//   state, which forms the verdict and loads it into the output register
//   once that register is free. Most of the time per item is spent in the
//   converter's shift-add-3 loop, which takes 3 bits per cycle.
//   The output register holds one verdict, so a new item is taken while a
//   verdict waits. If the receiver stalls, the finished verdict of the next
//   item waits inside until the output register frees, and in_stall stays
//   high meanwhile.
//   Reset (rst, synchronous) empties the output register and returns the
//   control to idle; any item in work is dropped.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier
  import lcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [CARD_W-1:0]    card_number,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VERDICT_W-1:0] verdict
);

  lcc_state_t state, state_next;

  logic               conv_start;
  logic               conv_done;
  logic [BCD_W-1:0]   conv_bcd;
  logic               scan_load;
  logic               scan_en;
  logic               out_load;
  logic               out_free;

  logic [BCD_W-1:0]   digits;
  logic [PAIR_W-1:0]  pair_idx;
  logic [DIGIT_W-1:0] luhn_sum;
  logic [LEN_W-1:0]   len;
  logic [DIGIT_W-1:0] lead_hi;
  logic [DIGIT_W-1:0] lead_lo;
  logic [DIGIT_W-1:0] prev_odd;

  logic [DIGIT_W-1:0] d_even;
  logic [DIGIT_W-1:0] d_odd;
  logic               len_ok;
  verdict_t           brand;
  verdict_t           verdict_calc;

  lcc_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .number (card_number),
    .done   (conv_done),
    .bcd    (conv_bcd)
  );

  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_CONV;
      ST_CONV:   if (conv_done) state_next = ST_SCAN;
      ST_SCAN:   if (pair_idx == PAIR_W'(NUM_PAIRS - 1)) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall   = (state != ST_IDLE);
    conv_start = (state == ST_IDLE) && in_valid;
    scan_load  = (state == ST_CONV) && conv_done;
    scan_en    = (state == ST_SCAN);
    out_load   = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Digit pair at the low end of the scan register
  assign d_even = digits[DIGIT_W-1:0];
  assign d_odd  = digits[2*DIGIT_W-1:DIGIT_W];

  // Digit scan: Luhn sum, length and the two leading digits
  always_ff @(posedge clk) begin
    if (scan_load) begin
      digits   <= conv_bcd;
      pair_idx <= '0;
      luhn_sum <= '0;
      len      <= '0;
      lead_hi  <= '0;
      lead_lo  <= '0;
      prev_odd <= '0;
    end else if (scan_en) begin
      digits   <= digits >> (2 * DIGIT_W);
      pair_idx <= pair_idx + 1'b1;
      luhn_sum <= mod10_add(luhn_sum, d_even, luhn_double(d_odd));
      prev_odd <= d_odd;
      // Numbers below 100 count as two digits: pair zero always sets them
      if (d_odd != '0 || pair_idx == '0) begin
        len     <= LEN_W'({pair_idx, 1'b0}) + LEN_W'(2);
        lead_hi <= d_odd;
        lead_lo <= d_even;
      end else if (d_even != '0) begin
        len     <= LEN_W'({pair_idx, 1'b1});
        lead_hi <= d_even;
        lead_lo <= prev_odd;
      end
    end
  end

  // Verdict from length, prefix and checksum
  always_comb begin
    len_ok = (len <= LEN_W'(MAX_DIGITS)) && (len == LEN_A || len == LEN_B || len == LEN_C);
    unique if (lead_hi == AMEX_HI && (lead_lo == AMEX_LO_A || lead_lo == AMEX_LO_B)) begin
      brand = VERDICT_AMEX;
    end else if (lead_hi == MC_HI && lead_lo <= MC_LO_MAX) begin
      brand = VERDICT_MASTERCARD;
    end else if (lead_hi == VISA_HI) begin
      brand = VERDICT_VISA;
    end else begin
      brand = VERDICT_INVALID;
    end
    verdict_calc = (len_ok && luhn_sum == '0) ? brand : VERDICT_INVALID;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      verdict <= verdict_calc;
    end
  end

`ifndef SYNTHESIS
  // An accepted item blocks the input on the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after accepting an item");

  // Converter finishes only while the control waits for it
  a_done_in_conv: assert property (@(posedge clk) disable iff (rst)
    conv_done |-> (state == ST_CONV))
    else $error("converter done outside conversion state");

  // A new verdict appears only from the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("output loaded outside finish state");

  // A brand is only reported for an accepted length
  a_brand_len: assert property (@(posedge clk) disable iff (rst)
    (out_load && verdict_calc != VERDICT_INVALID) |-> len_ok)
    else $error("brand reported with a rejected length");
`endif

endmodule
